// ----- src/hermite_spline_arc_length_assert.svh -----
// assertion macros for the hermite spline arc length block
// used by the controller, no other dependencies
`ifndef HERMITE_SPLINE_ARC_LENGTH_ASSERT_SVH
`define HERMITE_SPLINE_ARC_LENGTH_ASSERT_SVH

// same-cycle implication, checked outside reset
`define HSAL_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define HSAL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/hsal_pkg.sv -----
// types, widths, op codes and quadrature tables for the spline length block
// no dependencies
package hsal_pkg;

  localparam int CW        = 32;          // coordinate width
  localparam int DW        = CW + 7;      // signed width of c1, c2, u, d
  localparam int MW        = DW;          // magnitude width
  localparam int CH        = 16;          // multiplier digit width
  localparam int Q30_STEPS = (30 + CH - 1) / CH;
  localparam int SQ_STEPS  = (MW + CH - 1) / CH;
  localparam int BW        = CH * SQ_STEPS;
  localparam int PW        = MW + BW;
  localparam int SW        = 2 * DW;      // sum of squares
  localparam int RMW       = DW + 3;      // sqrt partial remainder
  localparam int ACW       = DW + 3;      // quadrature accumulator
  localparam int NW        = ACW + 1;     // dividend of the metre scaling
  localparam int STW       = $clog2(NW + 1);
  localparam int SEGW      = 32;
  localparam int TOTW      = 40;

  // divide by 200: drop three bits, then multiply by ceil(2^44 / 25) and keep bits from 44 up
  localparam logic [7:0]  DIV_HALF  = 8'd100;
  localparam logic [47:0] DIV_RECIP = 48'd703687441777;
  localparam int          DIV_SHIFT = 44;

  localparam logic [1:0] LAST_AXIS = 2'd2;
  localparam logic [2:0] LAST_NODE = 3'd4;

  localparam logic [2:0] OP_NONE = 3'd0;
  localparam logic [2:0] OP_C1   = 3'd1;
  localparam logic [2:0] OP_U    = 3'd2;
  localparam logic [2:0] OP_SQ   = 3'd3;
  localparam logic [2:0] OP_W    = 3'd4;
  localparam logic [2:0] OP_SQRT = 3'd5;
  localparam logic [2:0] OP_DIV  = 3'd6;

  typedef struct packed {
    logic                 first_point;
    logic signed [CW-1:0] loc_x;
    logic signed [CW-1:0] loc_y;
    logic signed [CW-1:0] loc_z;
    logic signed [CW-1:0] arrive_x;
    logic signed [CW-1:0] arrive_y;
    logic signed [CW-1:0] arrive_z;
    logic signed [CW-1:0] leave_x;
    logic signed [CW-1:0] leave_y;
    logic signed [CW-1:0] leave_z;
  } in_word_t;

  typedef struct packed {
    logic [SEGW-1:0] segment_length;
    logic [TOTW-1:0] total_length;
  } out_word_t;

  typedef struct packed {
    logic       load;
    logic       restart;
    logic       coef;
    logic       finish;
    logic       sum_clr;
    logic [2:0] op;
    logic [2:0] node;
    logic [1:0] axis;
  } dp_cmd_t;

  typedef struct packed {
    logic last;
    logic out_free;
  } dp_stat_t;

  function automatic logic [29:0] node_alpha(input logic [2:0] k);
    logic [29:0] r;
    unique case (k)
      3'd0:    r = 30'd536870912;
      3'd1:    r = 30'd247782407;
      3'd2:    r = 30'd825959417;
      3'd3:    r = 30'd50369310;
      3'd4:    r = 30'd1023372514;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [29:0] node_weight(input logic [2:0] k);
    logic [29:0] r;
    unique case (k)
      3'd0:    r = 30'd610839795;
      3'd1:    r = 30'd513923622;
      3'd2:    r = 30'd513923622;
      3'd3:    r = 30'd254398300;
      3'd4:    r = 30'd254398300;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [STW-1:0] step_last(input logic [2:0] op);
    logic [STW-1:0] r;
    unique case (op)
      OP_SQ, OP_DIV: r = STW'(SQ_STEPS - 1);
      OP_SQRT:       r = STW'(DW - 1);
      default:       r = STW'(Q30_STEPS - 1);
    endcase
    return r;
  endfunction

  function automatic logic [MW-1:0] mag(input logic signed [DW-1:0] x);
    logic signed [DW-1:0] n;
    n = -x;
    return x[DW-1] ? $unsigned(n) : $unsigned(x);
  endfunction

endpackage

// ----- src/hsal_dp.sv -----
// datapath: coefficients, shared digit multiplier, sqrt, divide by 200, totals
// depends on hsal_pkg
module hsal_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  hsal_pkg::in_word_t in_data,
  input  hsal_pkg::dp_cmd_t  cmd,
  output hsal_pkg::dp_stat_t stat,
  output logic               out_valid,
  input  logic               out_stall,
  output hsal_pkg::out_word_t out_data
);

  localparam int CW   = hsal_pkg::CW;
  localparam int DW   = hsal_pkg::DW;
  localparam int MW   = hsal_pkg::MW;
  localparam int CH   = hsal_pkg::CH;
  localparam int BW   = hsal_pkg::BW;
  localparam int PW   = hsal_pkg::PW;
  localparam int SW   = hsal_pkg::SW;
  localparam int RMW  = hsal_pkg::RMW;
  localparam int ACW  = hsal_pkg::ACW;
  localparam int NW   = hsal_pkg::NW;
  localparam int STW  = hsal_pkg::STW;
  localparam int SEGW = hsal_pkg::SEGW;
  localparam int TOTW = hsal_pkg::TOTW;

  hsal_pkg::in_word_t  in_r;
  hsal_pkg::out_word_t out_r;
  logic                out_valid_r;

  logic signed [CW-1:0] prev_loc_r [3];
  logic signed [CW-1:0] prev_lv_r  [3];
  logic signed [DW-1:0] c1_r [3];
  logic signed [DW-1:0] c2_r [3];
  logic signed [DW-1:0] c3_r [3];
  logic signed [DW-1:0] c1_nxt [3];
  logic signed [DW-1:0] c2_nxt [3];

  logic signed [CW-1:0] cur_loc [3];
  logic signed [CW-1:0] cur_arr [3];
  logic signed [CW-1:0] new_loc [3];
  logic signed [CW-1:0] new_lv  [3];

  logic signed [DW-1:0] u_r;
  logic [MW-1:0]        dmag_r;
  logic [SW-1:0]        sum_r;
  logic [PW-1:0]        prod_r;
  logic [SW-1:0]        rad_r;
  logic [RMW-1:0]       rem_r;
  logic [DW-1:0]        root_r;
  logic [ACW-1:0]       acc_r;
  logic [NW-1:0]        nq_r;
  logic [STW-1:0]       step_r;
  logic [TOTW-1:0]      total_r;

  assign cur_loc[0] = in_r.loc_x;
  assign cur_loc[1] = in_r.loc_y;
  assign cur_loc[2] = in_r.loc_z;
  assign cur_arr[0] = in_r.arrive_x;
  assign cur_arr[1] = in_r.arrive_y;
  assign cur_arr[2] = in_r.arrive_z;
  assign new_loc[0] = in_data.loc_x;
  assign new_loc[1] = in_data.loc_y;
  assign new_loc[2] = in_data.loc_z;
  assign new_lv[0]  = in_data.leave_x;
  assign new_lv[1]  = in_data.leave_y;
  assign new_lv[2]  = in_data.leave_z;

  // hermite coefficients, all three axes at once
  always_comb begin
    logic signed [DW-1:0] p0, p1, t0, t1, s, e;
    for (int i = 0; i < 3; i++) begin
      p0 = DW'(prev_loc_r[i]);
      p1 = DW'(cur_loc[i]);
      t0 = DW'(prev_lv_r[i]);
      t1 = DW'(cur_arr[i]);
      s  = ((p0 - p1) <<< 1) + t0 + t1;
      e  = p1 - p0;
      c1_nxt[i] = s + (s <<< 1);
      c2_nxt[i] = (e <<< 2) + (e <<< 1) - (t0 <<< 2) - (t1 <<< 1);
    end
  end

  // divide by 200 with rounding: (acc + 100) / 8 goes through the multiplier
  logic [NW-1:0] n_src;

  assign n_src = NW'(acc_r) + NW'(hsal_pkg::DIV_HALF);

  // shared multiplier, one 16 bit digit of b per cycle
  logic [MW-1:0]        mul_a;
  logic [BW-1:0]        mul_b;
  logic [BW-1:0]        mul_b_sh;
  logic [CH-1:0]        chunk;
  logic [MW+CH-1:0]     partial;
  logic [PW-1:0]        partial_sh;
  logic [PW-1:0]        prod_sum;
  logic [MW-1:0]        q30;
  logic signed [DW-1:0] qs;
  logic signed [DW-1:0] smul_res;
  logic                 neg;
  logic signed [DW-1:0] u_nxt;
  logic signed [DW-1:0] d_nxt;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    neg   = 1'b0;
    unique case (cmd.op)
      hsal_pkg::OP_C1: begin
        mul_a = hsal_pkg::mag(c1_r[cmd.axis]);
        mul_b = BW'(hsal_pkg::node_alpha(cmd.node));
        neg   = c1_r[cmd.axis][DW-1];
      end
      hsal_pkg::OP_U: begin
        mul_a = hsal_pkg::mag(u_r);
        mul_b = BW'(hsal_pkg::node_alpha(cmd.node));
        neg   = u_r[DW-1];
      end
      hsal_pkg::OP_SQ: begin
        mul_a = dmag_r;
        mul_b = BW'(dmag_r);
      end
      hsal_pkg::OP_W: begin
        mul_a = MW'(root_r);
        mul_b = BW'(hsal_pkg::node_weight(cmd.node));
      end
      hsal_pkg::OP_DIV: begin
        mul_a = n_src[3 +: MW];
        mul_b = BW'(hsal_pkg::DIV_RECIP);
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  assign mul_b_sh   = mul_b >> (CH * step_r);
  assign chunk      = mul_b_sh[CH-1:0];
  assign partial    = (MW+CH)'(mul_a) * (MW+CH)'(chunk);
  assign partial_sh = PW'(partial) << (CH * step_r);
  assign prod_sum   = ((step_r == '0) ? PW'(0) : prod_r) + partial_sh;
  assign q30        = prod_sum[30 +: MW];
  assign qs         = $signed(q30);
  assign smul_res   = neg ? -qs : qs;
  assign u_nxt      = smul_res + c2_r[cmd.axis];
  assign d_nxt      = smul_res + c3_r[cmd.axis];

  // restoring square root, one root bit per cycle
  logic [SW-1:0]  rad_src;
  logic [RMW-1:0] rem_src;
  logic [DW-1:0]  root_src;
  logic [RMW-1:0] rem_sh;
  logic [RMW-1:0] trial;
  logic           sq_ge;
  logic [RMW-1:0] rem_nxt;
  logic [DW-1:0]  root_nxt;

  assign rad_src  = (step_r == '0) ? sum_r : rad_r;
  assign rem_src  = (step_r == '0) ? '0 : rem_r;
  assign root_src = (step_r == '0) ? '0 : root_r;
  assign rem_sh   = {rem_src[RMW-3:0], rad_src[SW-1:SW-2]};
  assign trial    = RMW'({root_src, 2'b01});
  assign sq_ge    = rem_sh >= trial;
  assign rem_nxt  = sq_ge ? (rem_sh - trial) : rem_sh;
  assign root_nxt = {root_src[DW-2:0], sq_ge};

  // saturating segment and total
  logic [SEGW-1:0]  seg_sat;
  logic [TOTW:0]    tot_sum;
  logic [TOTW-1:0]  total_new;

  assign seg_sat   = (nq_r > NW'({SEGW{1'b1}})) ? {SEGW{1'b1}} : nq_r[SEGW-1:0];
  assign tot_sum   = {1'b0, total_r} + (TOTW+1)'(seg_sat);
  assign total_new = tot_sum[TOTW] ? {TOTW{1'b1}} : tot_sum[TOTW-1:0];

  assign stat.last     = step_r == hsal_pkg::step_last(cmd.op);
  assign stat.out_free = !out_valid_r || !out_stall;
  assign out_valid     = out_valid_r;
  assign out_data      = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.op != hsal_pkg::OP_NONE) begin
        step_r <= stat.last ? '0 : STW'(step_r + 1'b1);
      end
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.restart) begin
        total_r <= '0;
      end else if (cmd.finish) begin
        total_r <= total_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_r <= in_data;
    end
    for (int i = 0; i < 3; i++) begin
      if (cmd.restart) begin
        prev_loc_r[i] <= new_loc[i];
        prev_lv_r[i]  <= new_lv[i];
      end else if (cmd.finish) begin
        prev_loc_r[i] <= cur_loc[i];
        prev_lv_r[i]  <= (i == 0) ? in_r.leave_x : ((i == 1) ? in_r.leave_y : in_r.leave_z);
      end
      if (cmd.coef) begin
        c1_r[i] <= c1_nxt[i];
        c2_r[i] <= c2_nxt[i];
        c3_r[i] <= DW'(prev_lv_r[i]);
      end
    end
    if (cmd.coef) begin
      acc_r <= '0;
    end
    if (cmd.finish) begin
      out_r.segment_length <= seg_sat;
      out_r.total_length   <= total_new;
    end
    unique case (cmd.op)
      hsal_pkg::OP_C1: begin
        prod_r <= prod_sum;
        if (stat.last) u_r <= u_nxt;
      end
      hsal_pkg::OP_U: begin
        prod_r <= prod_sum;
        if (stat.last) dmag_r <= hsal_pkg::mag(d_nxt);
      end
      hsal_pkg::OP_SQ: begin
        prod_r <= prod_sum;
        if (stat.last) sum_r <= (cmd.sum_clr ? SW'(0) : sum_r) + prod_sum[SW-1:0];
      end
      hsal_pkg::OP_W: begin
        prod_r <= prod_sum;
        if (stat.last) acc_r <= acc_r + ACW'(q30);
      end
      hsal_pkg::OP_SQRT: begin
        rad_r  <= rad_src << 2;
        rem_r  <= rem_nxt;
        root_r <= root_nxt;
      end
      hsal_pkg::OP_DIV: begin
        prod_r <= prod_sum;
        if (stat.last) nq_r <= prod_sum[hsal_pkg::DIV_SHIFT +: NW];
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- src/hsal_ctrl.sv -----
// controller: sequences coefficients, five nodes of three axes, sqrt, scaling
// depends on hsal_pkg and hermite_spline_arc_length_assert.svh
`include "hermite_spline_arc_length_assert.svh"

module hsal_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_first,
  output logic               in_stall,
  input  hsal_pkg::dp_stat_t stat,
  output hsal_pkg::dp_cmd_t  cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_COEF = 4'd1;
  localparam logic [3:0] S_M1   = 4'd2;
  localparam logic [3:0] S_M2   = 4'd3;
  localparam logic [3:0] S_SQ   = 4'd4;
  localparam logic [3:0] S_SQRT = 4'd5;
  localparam logic [3:0] S_MW   = 4'd6;
  localparam logic [3:0] S_DIV  = 4'd7;
  localparam logic [3:0] S_FIN  = 4'd8;

  logic [3:0] state_r, state_nxt;
  logic [2:0] node_r, node_nxt;
  logic [1:0] axis_r, axis_nxt;
  logic       have_prev_r, have_prev_nxt;
  logic       accept;

  assign in_stall = state_r != S_IDLE;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_nxt     = state_r;
    node_nxt      = node_r;
    axis_nxt      = axis_r;
    have_prev_nxt = have_prev_r;
    cmd           = '0;
    cmd.node      = node_r;
    cmd.axis      = axis_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.load = 1'b1;
          if (in_first || !have_prev_r) begin
            cmd.restart   = 1'b1;
            have_prev_nxt = 1'b1;
          end else begin
            state_nxt = S_COEF;
          end
        end
      end
      S_COEF: begin
        cmd.coef  = 1'b1;
        node_nxt  = '0;
        axis_nxt  = '0;
        state_nxt = S_M1;
      end
      S_M1: begin
        cmd.op = hsal_pkg::OP_C1;
        if (stat.last) state_nxt = S_M2;
      end
      S_M2: begin
        cmd.op = hsal_pkg::OP_U;
        if (stat.last) state_nxt = S_SQ;
      end
      S_SQ: begin
        cmd.op      = hsal_pkg::OP_SQ;
        cmd.sum_clr = axis_r == '0;
        if (stat.last) begin
          if (axis_r == hsal_pkg::LAST_AXIS) begin
            axis_nxt  = '0;
            state_nxt = S_SQRT;
          end else begin
            axis_nxt  = axis_r + 2'd1;
            state_nxt = S_M1;
          end
        end
      end
      S_SQRT: begin
        cmd.op = hsal_pkg::OP_SQRT;
        if (stat.last) state_nxt = S_MW;
      end
      S_MW: begin
        cmd.op = hsal_pkg::OP_W;
        if (stat.last) begin
          if (node_r == hsal_pkg::LAST_NODE) begin
            state_nxt = S_DIV;
          end else begin
            node_nxt  = node_r + 3'd1;
            state_nxt = S_M1;
          end
        end
      end
      S_DIV: begin
        cmd.op = hsal_pkg::OP_DIV;
        if (stat.last) state_nxt = S_FIN;
      end
      S_FIN: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      node_r      <= '0;
      axis_r      <= '0;
      have_prev_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      node_r      <= node_nxt;
      axis_r      <= axis_nxt;
      have_prev_r <= have_prev_nxt;
    end
  end

  `HSAL_ASSERT_NEXT(a_restart_stays_idle, clk, rst_n, accept && (in_first || !have_prev_r), state_r == S_IDLE, "restart word started a segment")
  `HSAL_ASSERT_IMPL(a_node_range, clk, rst_n, 1'b1, node_r <= hsal_pkg::LAST_NODE, "node index out of range")
  `HSAL_ASSERT_IMPL(a_axis_range, clk, rst_n, 1'b1, axis_r <= hsal_pkg::LAST_AXIS, "axis index out of range")
  `HSAL_ASSERT_NEXT(a_div_to_fin, clk, rst_n, state_r == S_DIV && stat.last, state_r == S_FIN, "divide did not hand over to finish")
  `HSAL_ASSERT_IMPL(a_busy_has_prev, clk, rst_n, state_r != S_IDLE, have_prev_r, "segment work without a previous point")

endmodule

// ----- src/hermite_spline_arc_length.sv -----
// top level of the cubic hermite spline arc length block
// depends on hsal_pkg, hsal_ctrl and hsal_dp
//
// channel   direction  handshake            word
// in_       input      in_valid / in_stall   hsal_pkg::in_word_t
// out_      output     out_valid / out_stall hsal_pkg::out_word_t
//
// a word with first_point set, or any word before the first one, is taken
// in its accept cycle and gives no result. any other word goes through the
// accept cycle, the coefficients, then per node three axes of two q30
// products and a square, a square root and a weight product, then a
// reciprocal product for the divide by 200 and a write of the result. the
// digit multiplier is shared and the root is bit serial. reset clears the
// total and the flag that marks a held point; a stalled result holds in the
// output register, and a new word is taken while it waits, with only the
// final write held back
module hermite_spline_arc_length (
  input  logic                clk,
  input  logic                rst_n,
  // input channel
  input  logic                in_valid,
  output logic                in_stall,
  input  hsal_pkg::in_word_t  in_data,
  // result channel
  output logic                out_valid,
  input  logic                out_stall,
  output hsal_pkg::out_word_t out_data
);

  // command and status between sequencer and datapath
  hsal_pkg::dp_cmd_t  cmd;
  hsal_pkg::dp_stat_t stat;

  // sequencer: node and axis counters, handshake on the input side
  hsal_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_first (in_data.first_point),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath: arithmetic, held point, running total, output register
  hsal_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
